/* hw/rtl/acc_pkg.sv */
// ----------------------------------------------------------------------------
// acc_pkg
// Types and constants of the alpha chamfer center block.
// ----------------------------------------------------------------------------
package acc_pkg;

	localparam int DIST_W = 10;
	localparam logic [DIST_W-1:0] INF_MARGIN = 10'd10;
	localparam logic [7:0] THRESH_RST = 8'd77;

	localparam logic [1:0] CFG_THRESH = 2'd0;
	localparam logic [1:0] CFG_WIDTH  = 2'd1;
	localparam logic [1:0] CFG_HEIGHT = 2'd2;

	typedef struct packed {
		logic [7:0] alpha;
		logic       last_pixel;
	} req_t;

	typedef struct packed {
		logic [15:0] center_x_fixed;
		logic        found;
		logic        method;
	} rsp_t;

	// frame job handed from the load front to the compute back
	typedef struct packed {
		logic [20:0] count;
		logic [10:0] w;
		logic [10:0] h;
		logic [10:0] min_x;
		logic [10:0] max_x;
		logic        any;
	} job_t;

endpackage

/* hw/rtl/acc_front.sv */
// ----------------------------------------------------------------------------
// acc_front
// Pixel load front: classifies pixels, tracks opaque bounds, posts frame jobs.
// ----------------------------------------------------------------------------
module acc_front #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  acc_pkg::req_t req,
	input  logic [7:0]   thresh,
	input  logic [10:0]  w_use,
	input  logic [10:0]  h_use,
	input  logic         hold,
	output logic         pix_we,
	output logic [$clog2(MAX_WIDTH*MAX_HEIGHT+1)-1:0] pix_addr,
	output logic         pix_opq,
	output logic         job_valid,
	output acc_pkg::job_t job
);
	import acc_pkg::*;
	localparam int CW = $clog2(MAX_WIDTH*MAX_HEIGHT+1);

	logic [CW-1:0] cnt_q;
	logic [10:0] x_q, min_q, max_q;
	logic any_q;
	logic [21:0] n;
	logic inb, opq;

	assign n = 22'(w_use) * 22'(h_use);
	assign inb = 22'(cnt_q) < n;
	assign opq = req.alpha > thresh;
	assign pix_we = start && !hold && inb;
	assign pix_addr = cnt_q;
	assign pix_opq = opq;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0; x_q <= '0; max_q <= '0; any_q <= 1'b0;
			min_q <= (MAX_WIDTH < 256) ? 11'(MAX_WIDTH) : 11'd256;
			job_valid <= 1'b0; job <= '0;
		end else begin
			job_valid <= 1'b0;
			if (start && !hold) begin
				if (inb) begin
					cnt_q <= cnt_q + 1'b1;
					x_q <= (x_q + 11'd1 >= w_use) ? 11'd0 : x_q + 11'd1;
					if (opq) begin
						if (x_q < min_q) min_q <= x_q;
						if (!any_q || x_q > max_q) max_q <= x_q;
						any_q <= 1'b1;
					end
				end
				if (req.last_pixel) begin
					job_valid <= 1'b1;
					job.count <= 21'(cnt_q) + 21'(inb);
					job.w <= w_use; job.h <= h_use;
					if (inb && opq) begin
						job.min_x <= (x_q < min_q) ? x_q : min_q;
						job.max_x <= (!any_q || x_q > max_q) ? x_q : max_q;
					end else begin
						job.min_x <= min_q; job.max_x <= max_q;
					end
					job.any <= any_q || (inb && opq);
					cnt_q <= '0; x_q <= '0; any_q <= 1'b0; min_q <= w_use;
				end
			end
		end
	end
endmodule

/* hw/rtl/acc_div.sv */
// ----------------------------------------------------------------------------
// acc_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module acc_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  logic [47:0] num,
	input  logic [31:0] den,
	output logic        done,
	output logic [47:0] quo
);
	logic [5:0] k_q;
	logic busy_q;
	logic [32:0] rem_q;
	logic [47:0] n_q;
	logic [32:0] t;

	assign t = {rem_q[31:0], n_q[47]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0; done <= 1'b0; k_q <= '0; rem_q <= '0; n_q <= '0; quo <= '0;
		end else begin
			done <= 1'b0;
			if (go) begin
				busy_q <= 1'b1; k_q <= 6'd48; rem_q <= '0; n_q <= num; quo <= '0;
			end else if (busy_q) begin
				n_q <= {n_q[46:0], 1'b0};
				if (t >= {1'b0, den}) begin
					rem_q <= t - {1'b0, den}; quo <= {quo[46:0], 1'b1};
				end else begin
					rem_q <= t; quo <= {quo[46:0], 1'b0};
				end
				k_q <= k_q - 6'd1;
				if (k_q == 6'd1) begin
					busy_q <= 1'b0; done <= 1'b1;
				end
			end
		end
	end
endmodule

/* hw/rtl/acc_back.sv */
// ----------------------------------------------------------------------------
// acc_back
// Compute back: distance store, two chamfer passes, sum pass and divide.
// ----------------------------------------------------------------------------
module acc_back #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          pix_we,
	input  logic [$clog2(MAX_WIDTH*MAX_HEIGHT+1)-1:0] pix_addr,
	input  logic          pix_opq,
	input  logic          job_valid,
	input  acc_pkg::job_t job_in,
	output logic          job_pop,
	output logic          rsp_valid,
	output acc_pkg::rsp_t rsp
);
	import acc_pkg::*;
	localparam int DEPTH = MAX_WIDTH*MAX_HEIGHT;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	localparam logic [2:0] ST_IDLE = 3'd0, ST_RD = 3'd1, ST_WT = 3'd2,
		ST_WR = 3'd3, ST_DIV = 3'd4, ST_OUT = 3'd5;

	// store holds 1 for content, 0 for background; passes rewrite it
	logic [DIST_W-1:0] mem [DEPTH];
	logic [DIST_W-1:0] rd_q;

	logic [2:0] st_q;
	logic [1:0] pass_q, nb_q;
	logic [10:0] x_q, y_q;
	logic [DIST_W-1:0] d_q, inf_q;
	logic [25:0] ws_q;
	logic [33:0] wx_q;
	job_t j_q;
	logic [AW-1:0] ra, wa;
	logic [DIST_W-1:0] wd;
	logic we;
	logic div_go_q, div_done;
	logic [47:0] quo;
	logic [21:0] lin;
	logic [10:0] nx, ny;
	logic nok, inrange;
	logic [DIST_W-1:0] cand, cur;

	assign lin = 22'(y_q) * 22'(j_q.w) + 22'(x_q);
	assign inrange = lin < 22'(j_q.count);

	// neighbor offsets per pass; nb 0,1 side neighbors, 2,3 diagonals
	always_comb begin
		nx = x_q; ny = y_q; nok = 1'b1;
		unique case (pass_q)
			2'd0: begin
				unique case (nb_q)
					2'd0: begin nx = x_q - 11'd1; nok = x_q != 0; end
					2'd1: begin ny = y_q - 11'd1; nok = y_q != 0; end
					2'd2: begin nx = x_q - 11'd1; ny = y_q - 11'd1;
						nok = x_q != 0 && y_q != 0; end
					default: begin nx = x_q + 11'd1; ny = y_q - 11'd1;
						nok = x_q + 11'd1 < j_q.w && y_q != 0; end
				endcase
			end
			default: begin
				unique case (nb_q)
					2'd0: begin nx = x_q + 11'd1; nok = x_q + 11'd1 < j_q.w; end
					2'd1: begin ny = y_q + 11'd1; nok = y_q + 11'd1 < j_q.h; end
					2'd2: begin nx = x_q + 11'd1; ny = y_q + 11'd1;
						nok = x_q + 11'd1 < j_q.w && y_q + 11'd1 < j_q.h; end
					default: begin nx = x_q - 11'd1; ny = y_q + 11'd1;
						nok = x_q != 0 && y_q + 11'd1 < j_q.h; end
				endcase
			end
		endcase
	end

	logic [21:0] nlin;
	logic sub_q;
	assign nlin = 22'(ny) * 22'(j_q.w) + 22'(nx);

	assign cand = rd_q + ((nb_q[1]) ? 10'd2 : 10'd1);

	always_comb begin
		ra = sub_q ? AW'(nlin) : AW'(lin);
	end

	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		rd_q <= mem[ra];
	end

	always_comb begin
		we = pix_we; wa = AW'(pix_addr); wd = {9'd0, pix_opq};
		if (st_q == ST_WR) begin
			we = 1'b1; wa = AW'(lin); wd = d_q;
		end
	end

	// prepass value: during forward pass the raw 0/1 self read maps to inf (content) or 0 (background or unloaded)
	assign cur = (pass_q == 2'd0) ? ((inrange && rd_q != 0) ? inf_q : 10'd0) : rd_q;

	logic [10:0] w_m1, h_m1;
	assign w_m1 = j_q.w - 11'd1;
	assign h_m1 = j_q.h - 11'd1;

	acc_div u_div (
		.clk(clk), .arst_n(arst_n), .go(div_go_q), .num({6'd0, wx_q, 8'd0}),
		.den({6'd0, ws_q}), .done(div_done), .quo(quo)
	);

	logic last_px;
	assign last_px = (pass_q == 2'd1) ? (x_q == 0 && y_q == 0)
		: (x_q == w_m1 && y_q == h_m1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE; pass_q <= '0; nb_q <= '0; sub_q <= 1'b0;
			x_q <= '0; y_q <= '0; d_q <= '0; inf_q <= '0; ws_q <= '0; wx_q <= '0;
			j_q <= '0; rsp_valid <= 1'b0; rsp <= '0; job_pop <= 1'b0;
			div_go_q <= 1'b0;
		end else begin
			rsp_valid <= 1'b0; job_pop <= 1'b0; div_go_q <= 1'b0;
			unique case (st_q)
				ST_IDLE: if (job_valid && !job_pop) begin
					j_q <= job_in; job_pop <= 1'b1;
					inf_q <= 10'(job_in.w + job_in.h) + INF_MARGIN;
					pass_q <= 2'd0; x_q <= '0; y_q <= '0; sub_q <= 1'b0; nb_q <= '0;
					ws_q <= '0; wx_q <= '0; st_q <= ST_RD;
				end
				ST_RD: st_q <= ST_WT;
				ST_WT: begin
					if (!sub_q) begin
						d_q <= cur;
						if (cur == 0 || pass_q == 2'd2) st_q <= ST_WR;
						else begin sub_q <= 1'b1; nb_q <= 2'd0; st_q <= ST_RD; end
					end else begin
						if (nok && cand < d_q) d_q <= cand;
						if (nb_q == 2'd3) begin sub_q <= 1'b0; st_q <= ST_WR; end
						else begin nb_q <= nb_q + 2'd1; st_q <= ST_RD; end
					end
				end
				ST_WR: begin
					if (pass_q == 2'd2 && d_q != 0 && d_q < inf_q) begin
						ws_q <= ws_q + 26'(d_q);
						wx_q <= wx_q + 34'(20'(d_q) * 20'(x_q));
					end
					st_q <= ST_RD;
					if (pass_q == 2'd1) begin
						if (x_q == 0) begin x_q <= w_m1; y_q <= y_q - 11'd1; end
						else x_q <= x_q - 11'd1;
					end else begin
						if (x_q == w_m1) begin x_q <= '0; y_q <= y_q + 11'd1; end
						else x_q <= x_q + 11'd1;
					end
					if (last_px) begin
						unique case (pass_q)
							2'd0: begin pass_q <= 2'd1; x_q <= w_m1; y_q <= h_m1; end
							2'd1: begin pass_q <= 2'd2; x_q <= '0; y_q <= '0; end
							default: begin
								if (ws_q != 0 || (d_q != 0 && d_q < inf_q)) begin
									st_q <= ST_DIV; div_go_q <= 1'b1;
								end else begin
									rsp_valid <= 1'b1;
									rsp.found <= j_q.any; rsp.method <= j_q.any;
									rsp.center_x_fixed <= j_q.any
										? 16'((j_q.min_x + j_q.max_x) * 128) : 16'd0;
									st_q <= ST_IDLE;
								end
							end
						endcase
					end
				end
				ST_DIV: if (div_done) begin
					rsp_valid <= 1'b1; rsp.found <= 1'b1; rsp.method <= 1'b0;
					rsp.center_x_fixed <= quo[15:0]; st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end
endmodule

/* hw/rtl/alpha_chamfer_center_x_top.sv */
// ----------------------------------------------------------------------------
// alpha_chamfer_center_x_top
// Alpha image content center x via 1/2 chamfer distance weighted centroid.
// ----------------------------------------------------------------------------
// Pixels load one per cycle while start is high and busy is low. After the last
// pixel: forward and backward passes take a self read and a write per background
// pixel and also one store read per neighbor per content pixel, then the sum pass,
// then a divide when the weight sum is nonzero. Result strobes one cycle; receiver cannot stall.
// busy is high while a frame computes. Reset clears control; the store is not cleared.
module alpha_chamfer_center_x_top #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  acc_pkg::req_t req,
	output logic          strobe,
	output acc_pkg::rsp_t rsp,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [1:0]    cfg_index,
	input  logic [8:0]    cfg_data
);
	import acc_pkg::*;
	localparam int CW = $clog2(MAX_WIDTH*MAX_HEIGHT+1);

	logic [7:0] thr_q;
	logic [8:0] w_q, h_q;
	logic [10:0] w_use, h_use;
	logic pix_we, pix_opq, job_valid, job_pop, jq_v_q;
	logic [CW-1:0] pix_addr;
	job_t job, jq_q;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THRESH_RST; w_q <= 9'd256; h_q <= 9'd256;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_THRESH: thr_q <= cfg_data[7:0];
				CFG_WIDTH:  w_q <= cfg_data;
				CFG_HEIGHT: h_q <= cfg_data;
				default: ;
			endcase
		end
	end
	assign w_use = (w_q == 0) ? 11'd1 : (32'(w_q) > MAX_WIDTH) ? 11'(MAX_WIDTH) : 11'(w_q);
	assign h_use = (h_q == 0) ? 11'd1 : (32'(h_q) > MAX_HEIGHT) ? 11'(MAX_HEIGHT) : 11'(h_q);

	// one-entry job queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jq_v_q <= 1'b0; jq_q <= '0;
		end else if (job_valid) begin
			jq_v_q <= 1'b1; jq_q <= job;
		end else if (job_pop) jq_v_q <= 1'b0;
	end

	logic back_busy_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) back_busy_q <= 1'b0;
		else if (job_valid) back_busy_q <= 1'b1;
		else if (strobe) back_busy_q <= 1'b0;
	end
	assign busy = back_busy_q || job_valid;

	acc_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .req(req), .thresh(thr_q),
		.w_use(w_use), .h_use(h_use), .hold(busy), .pix_we(pix_we),
		.pix_addr(pix_addr), .pix_opq(pix_opq), .job_valid(job_valid), .job(job)
	);

	acc_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_back (
		.clk(clk), .arst_n(arst_n), .pix_we(pix_we), .pix_addr(pix_addr),
		.pix_opq(pix_opq), .job_valid(jq_v_q), .job_in(jq_q), .job_pop(job_pop),
		.rsp_valid(strobe), .rsp(rsp)
	);
endmodule

/* hw/rtl/acc_checker.sv */
// ----------------------------------------------------------------------------
// acc_checker
// Port-level checks of the alpha chamfer center block.
// ----------------------------------------------------------------------------
module acc_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input logic          strobe,
	input acc_pkg::rsp_t rsp
);
	import acc_pkg::*;
	a_nf: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !rsp.found |-> rsp.center_x_fixed == 16'd0 && !rsp.method)
		else $error("not found result carries data");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(busy))
		else $error("result without busy");
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |=> !strobe)
		else $error("double result");
endmodule

bind alpha_chamfer_center_x_top acc_checker u_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .strobe(strobe), .rsp(rsp)
);
